// ===== hdl/bole_pkg.sv =====
// Package: shared types, constants and opcodes for the ordered list engine.
`timescale 1ns / 1ps
package bole_pkg;
   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [3:0] OP_INS_FRONT = 4'd0;
   localparam logic [3:0] OP_INS_BACK  = 4'd1;
   localparam logic [3:0] OP_REM_FRONT = 4'd2;
   localparam logic [3:0] OP_REM_BACK  = 4'd3;
   localparam logic [3:0] OP_REM_VALUE = 4'd4;
   localparam logic [3:0] OP_INS_AT    = 4'd5;
   localparam logic [3:0] OP_REM_AT    = 4'd6;
   localparam logic [3:0] OP_SORT      = 4'd7;
   localparam logic [3:0] OP_DUMP      = 4'd8;

   typedef struct packed {
      logic [3:0]         opcode;
      logic signed [31:0] item_value;
      logic [4:0]         position;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [4:0]         count;
      logic signed [31:0] element;
      logic               last;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;     // capture request and run the operation
      logic sort_pass; // one odd/even transposition pass
      logic dump_sel; // present the dump entry
      logic dump_adv; // advance dump index
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic is_sort;
      logic is_dump;
      logic sort_done;
      logic dump_last;
   } sts_type;
endpackage

// ===== hdl/bole_datapath.sv =====
// Datapath: register-file list with parallel shift, compare and sort network.
`timescale 1ns / 1ps
module bole_datapath
   import bole_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type result
);
   logic signed [31:0] store_ff [DEPTH];
   logic signed [31:0] store_in [DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] pass_ff, pass_in;
   logic [IDX_W-1:0] didx_ff, didx_in;
   logic [3:0]       op_ff, op_in;
   logic             ok_ff, ok_in;

   logic [DEPTH-1:0] hit;
   logic [DEPTH-1:0] before_hit;
   logic             any_hit;
   logic [CNT_W-1:0] pos_c;
   logic             full, empty, pos_ok;
   logic [CNT_W-1:0] ins_idx;
   logic             do_ins, do_rem;

   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);
   assign pos_c  = CNT_W'(req.position);
   assign pos_ok = (req.position != '0) && (pos_c <= count_ff);

   always_comb begin
      for (int i = 0; i < DEPTH; i++)
         hit[i] = (CNT_W'(i) < count_ff) && (store_ff[i] == req.item_value);
      before_hit[0] = 1'b0;
      for (int i = 1; i < DEPTH; i++)
         before_hit[i] = before_hit[i-1] | hit[i-1];
      any_hit = |hit;
   end

   always_comb begin
      store_in = store_ff;
      count_in = count_ff;
      pass_in  = pass_ff;
      didx_in  = didx_ff;
      op_in    = op_ff;
      ok_in    = ok_ff;
      do_ins   = 1'b0;
      do_rem   = 1'b0;
      ins_idx  = '0;
      if (cmd.load) begin
         op_in   = req.opcode;
         ok_in   = 1'b0;
         pass_in = '0;
         didx_in = '0;
         case (req.opcode)
            OP_INS_FRONT: begin do_ins = !full; ins_idx = '0; end
            OP_INS_BACK:  begin do_ins = !full; ins_idx = count_ff; end
            OP_REM_FRONT: begin do_rem = !empty; end
            OP_REM_BACK: begin
               if (!empty) begin ok_in = 1'b1; count_in = count_ff - 1'b1; end
            end
            OP_REM_VALUE: begin do_rem = any_hit; end
            OP_INS_AT: begin do_ins = !full && pos_ok; ins_idx = pos_c - 1'b1; end
            OP_REM_AT: begin do_rem = pos_ok; end
            OP_SORT, OP_DUMP: ok_in = 1'b1;
            default: ok_in = 1'b0;
         endcase
         if (do_ins) begin
            ok_in    = 1'b1;
            count_in = count_ff + 1'b1;
            for (int i = 1; i < DEPTH; i++)
               if (CNT_W'(i) > ins_idx) store_in[i] = store_ff[i-1];
            for (int i = 0; i < DEPTH; i++)
               if (CNT_W'(i) == ins_idx) store_in[i] = req.item_value;
         end
         if (do_rem) begin
            ok_in    = 1'b1;
            count_in = count_ff - 1'b1;
            for (int i = 0; i < DEPTH - 1; i++) begin
               if (req.opcode == OP_REM_VALUE) begin
                  if (hit[i] || before_hit[i]) store_in[i] = store_ff[i+1];
               end else if (req.opcode == OP_REM_AT) begin
                  if (CNT_W'(i) >= pos_c - 1'b1) store_in[i] = store_ff[i+1];
               end else begin
                  store_in[i] = store_ff[i+1];
               end
            end
         end
      end
      if (cmd.sort_pass) begin
         // compare-exchange pairs starting at the parity of the pass number
         for (int i = 0; i < DEPTH - 1; i++)
            if ((i % 2) == int'(pass_ff[0]) && CNT_W'(i + 1) < count_ff
                && store_ff[i+1] < store_ff[i]) begin
               store_in[i]   = store_ff[i+1];
               store_in[i+1] = store_ff[i];
            end
         pass_in = pass_ff + 1'b1;
      end
      if (cmd.dump_adv) didx_in = didx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
      op_ff    <= op_in;
      ok_ff    <= ok_in;
      pass_ff  <= pass_in;
      didx_ff  <= didx_in;
      if (reset) count_ff <= '0;
      else       count_ff <= count_in;
   end

   assign sts.is_sort   = (op_ff == OP_SORT);
   assign sts.is_dump   = (op_ff == OP_DUMP);
   assign sts.sort_done = (pass_ff >= count_ff);
   assign sts.dump_last = (CNT_W'(didx_ff) + 1'b1 >= count_ff);

   always_comb begin
      result.ok      = ok_ff;
      result.count   = 5'(count_ff);
      result.element = '0;
      result.last    = 1'b1;
      if (cmd.dump_sel && !empty) begin
         result.element = store_ff[didx_ff];
         result.last    = sts.dump_last;
      end
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH)) else $error("count overflow");
   a_pass_step: assert property (@(posedge clock) disable iff (reset)
      cmd.sort_pass |=> pass_ff == $past(pass_ff) + 1'b1) else $error("pass step");
   a_sort_cnt: assert property (@(posedge clock) disable iff (reset)
      cmd.sort_pass |=> $stable(count_ff)) else $error("sort changed count");
   a_dump_cnt: assert property (@(posedge clock) disable iff (reset)
      cmd.dump_adv |=> $stable(count_ff)) else $error("dump changed count");
endmodule

// ===== hdl/bole_control.sv =====
// Controller: sequences load, sort passes, dump and result handshake.
`timescale 1ns / 1ps
module bole_control
   import bole_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SORT = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;
   localparam logic [1:0] ST_DUMP = 2'd3;

   logic [1:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT) || (state_ff == ST_DUMP);

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.dump_sel  = (state_ff == ST_DUMP);
      case (state_ff)
         ST_IDLE: if (req_valid) begin
            cmd.load = 1'b1;
            state_in = ST_SORT;
         end
         ST_SORT: begin
            if (sts.is_sort && !sts.sort_done) cmd.sort_pass = 1'b1;
            else if (sts.is_dump) state_in = ST_DUMP;
            else state_in = ST_OUT;
         end
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         ST_DUMP: if (rsp_ready) begin
            if (sts.dump_last) state_in = ST_IDLE;
            else cmd.dump_adv = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.sort_pass, cmd.dump_adv})) else $error("cmd clash");
   a_no_rsp_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !rsp_valid) else $error("load during response");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
endmodule

// ===== hdl/bounded_ordered_list_engine_core.sv =====
// Top level: ordered list engine built from a controller and a datapath.
`timescale 1ns / 1ps
// Usage:
//   Input channel req_* carries one transaction: opcode, item_value, position.
//   Result channel rsp_* returns ok, count, element, last for each result.
//   Inserts and removes shift all entries in parallel in the load cycle; the
//   controller then passes through its sequencing state (ST_SORT) before
//   rsp_valid rises in ST_OUT; ready returns the cycle after rsp is taken,
//   so a new request is accepted only after the previous result is taken.
//   Sort runs count odd/even transposition passes, one per cycle.
//   Dump streams count results, one per cycle while rsp_ready is high, with
//   last marking the final one; an empty list gives a single result.
//   Reset clears the count and controller; stored entries need no clearing.
//   A receiver stall holds the current result stable and blocks new requests.
module bounded_ordered_list_engine_core
   import bole_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   cmd_type cmd;
   sts_type sts;

   // sequence the transaction
   bole_control u_control (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd
   );

   // hold the list and compute results
   bole_datapath u_datapath (
      .clock, .reset, .req(req_data), .cmd, .sts, .result(rsp_data)
   );
endmodule
